// ----- hdl/srm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send/receive matcher package
// Shared widths, action and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package srm_pkg;

   // Rank space is fixed by the 4-bit rank fields.
   localparam int MAX_RANKS = 16;
   localparam int RANK_W    = 4;
   localparam int PAIRS     = MAX_RANKS * MAX_RANKS;
   localparam int PAIR_W    = 2 * RANK_W;
   localparam int COUNT_W   = 5;
   localparam int HANDLE_W  = 16;
   localparam int SIZE_W    = 32;
   localparam int ACTION_W  = 2;
   localparam int STATUS_W  = 3;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SEND   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_RECV   = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_DONE      = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic lookup;
      logic fetch;
      logic load_out;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_fetch;
   } dp_status_type;

endpackage

// ----- hdl/srm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/srm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send/receive matcher controller
// Sequences one request through pointer lookup, optional entry fetch and
// delivery into the response register.
// ----------------------------------------------------------------------------
module srm_ctrl import srm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LOOKUP = 2'd1;
   localparam logic [1:0] S_FETCH  = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // The response register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            if (dp_status.need_fetch) begin
               state_in = S_FETCH;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The response stays valid until its transfer completes.
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/srm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send/receive matcher datapath
// Holds the participant table, the per-pair queue pointers and the queued
// send and receive entries, and builds the response.
// ----------------------------------------------------------------------------
module srm_datapath import srm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       dp_status,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [RANK_W-1:0]   req_source_rank,
   input  logic [RANK_W-1:0]   req_dest_rank,
   input  logic [HANDLE_W-1:0] req_request_handle,
   input  logic [SIZE_W-1:0]   req_request_size,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [RANK_W-1:0]   rsp_assigned_rank,
   output logic [HANDLE_W-1:0] rsp_matched_send_handle,
   output logic [HANDLE_W-1:0] rsp_matched_recv_handle,
   output logic [SIZE_W-1:0]   rsp_matched_size,
   output logic                rsp_size_mismatch,
   output logic [COUNT_W-1:0]  rsp_live_count
);

   localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = FILL_W + 1;
   localparam int SIDE_W  = HEAD_W + FILL_W;
   localparam int PTR_W   = 2 * SIDE_W;
   localparam int SLOTS   = PAIRS * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ENTRY_W = HANDLE_W + SIZE_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   assigned_rank;
      logic [HANDLE_W-1:0] send_handle;
      logic [HANDLE_W-1:0] recv_handle;
      logic [SIZE_W-1:0]   size;
      logic                mismatch;
      logic [COUNT_W-1:0]  live_count;
   } result_type;

   // Captured request.
   logic [ACTION_W-1:0] action_ff;
   logic [RANK_W-1:0]   src_ff, dst_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [PAIR_W-1:0]   pair_ff;

   // Participant state.
   logic [MAX_RANKS-1:0] alive_ff, alive_in;
   logic [COUNT_W-1:0]   next_rank_ff, next_rank_in;
   logic [COUNT_W-1:0]   alive_total_ff, alive_total_in;

   // Pointer store and its per-pair valid bits.
   logic [PAIRS-1:0] ptr_valid_ff;
   logic [PTR_W-1:0] ptr_rdata, ptr_word, ptr_wdata;
   logic             ptr_wr;

   logic [HEAD_W-1:0] send_head, recv_head, opp_head, own_head, new_head;
   logic [FILL_W-1:0] send_fill, recv_fill, opp_fill, own_fill;
   logic [SUM_W-1:0]  slot_sum, slot_wrap;
   logic [HEAD_W-1:0] slot;
   logic [ADDR_W-1:0] entry_addr;
   logic              is_send, do_pop, do_push;

   // Entry stores.
   logic [ENTRY_W-1:0] send_rdata, recv_rdata, opp_data;
   logic [HANDLE_W-1:0] pop_handle;
   logic [SIZE_W-1:0]   pop_size;

   result_type look_res, fetch_res, result_now, hold_ff, out_ff;

   // Capture the request on its transfer.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         src_ff    <= req_source_rank;
         dst_ff    <= req_dest_rank;
         handle_ff <= req_request_handle;
         size_ff   <= req_request_size;
      end
   end

   assign pair_ff = {src_ff, dst_ff};

   // Pointer word read at the transfer, used in the lookup cycle.
   srm_ram #(
      .WIDTH (PTR_W),
      .DEPTH (PAIRS)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_wr),
      .wr_addr (pair_ff),
      .wr_data (ptr_wdata),
      .rd_en   (cmd.accept),
      .rd_addr ({req_source_rank, req_dest_rank}),
      .rd_data (ptr_rdata)
   );

   // A pair never written reads as empty queues.
   assign ptr_word  = ptr_valid_ff[pair_ff] ? ptr_rdata : '0;
   assign send_head = ptr_word[PTR_W-1 -: HEAD_W];
   assign send_fill = ptr_word[PTR_W-HEAD_W-1 -: FILL_W];
   assign recv_head = ptr_word[SIDE_W-1 -: HEAD_W];
   assign recv_fill = ptr_word[FILL_W-1:0];

   assign is_send  = (action_ff == ACT_SEND);
   assign opp_head = is_send ? recv_head : send_head;
   assign opp_fill = is_send ? recv_fill : send_fill;
   assign own_head = is_send ? send_head : recv_head;
   assign own_fill = is_send ? send_fill : recv_fill;

   // Tail slot of the own queue, wrapped once.
   assign slot_sum  = SUM_W'(own_head) + SUM_W'(own_fill);
   assign slot_wrap = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      (slot_sum - SUM_W'(QUEUE_DEPTH)) : slot_sum;
   assign new_head  = (opp_head == HEAD_W'(QUEUE_DEPTH - 1)) ?
                      '0 : (opp_head + HEAD_W'(1));

   // Lookup: participant actions and queue decisions.
   always_comb begin
      alive_in       = alive_ff;
      next_rank_in   = next_rank_ff;
      alive_total_in = alive_total_ff;
      do_pop         = 1'b0;
      do_push        = 1'b0;
      look_res       = '0;
      ptr_wdata      = ptr_word;
      case (action_ff)
         ACT_ADD: begin
            if (next_rank_ff >= COUNT_W'(MAX_RANKS)) begin
               look_res.status = ST_EXHAUSTED;
            end else begin
               alive_in[next_rank_ff[RANK_W-1:0]] = 1'b1;
               next_rank_in           = next_rank_ff + COUNT_W'(1);
               alive_total_in         = alive_total_ff + COUNT_W'(1);
               look_res.assigned_rank = next_rank_ff[RANK_W-1:0];
               look_res.status        = ST_DONE;
            end
         end
         ACT_REMOVE: begin
            if (alive_ff[src_ff]) begin
               alive_in[src_ff] = 1'b0;
               alive_total_in   = alive_total_ff - COUNT_W'(1);
               look_res.status  = ST_DONE;
            end else begin
               look_res.status = ST_UNKNOWN;
            end
         end
         default: begin
            if (!alive_ff[src_ff] || !alive_ff[dst_ff]) begin
               look_res.status = ST_UNKNOWN;
            end else if (opp_fill != '0) begin
               do_pop          = 1'b1;
               look_res.status = ST_MATCHED;
               if (is_send) begin
                  ptr_wdata = {send_head, send_fill, new_head,
                               recv_fill - FILL_W'(1)};
               end else begin
                  ptr_wdata = {new_head, send_fill - FILL_W'(1),
                               recv_head, recv_fill};
               end
            end else if (own_fill < FILL_W'(QUEUE_DEPTH)) begin
               do_push         = 1'b1;
               look_res.status = ST_QUEUED;
               if (is_send) begin
                  ptr_wdata = {send_head, send_fill + FILL_W'(1),
                               recv_head, recv_fill};
               end else begin
                  ptr_wdata = {send_head, send_fill,
                               recv_head, recv_fill + FILL_W'(1)};
               end
            end else begin
               look_res.status = ST_FULL;
            end
         end
      endcase
      look_res.live_count = alive_total_in;
   end

   assign ptr_wr               = cmd.lookup && (do_pop || do_push);
   assign dp_status.need_fetch = do_pop;

   // Entry address: head slot for a pop, tail slot for a push.
   assign slot       = do_pop ? opp_head : slot_wrap[HEAD_W-1:0];
   assign entry_addr = ADDR_W'(pair_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);

   srm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_send_ram (
      .clock   (clock),
      .wr_en   (cmd.lookup && do_push && is_send),
      .wr_addr (entry_addr),
      .wr_data ({handle_ff, size_ff}),
      .rd_en   (cmd.lookup && do_pop && !is_send),
      .rd_addr (entry_addr),
      .rd_data (send_rdata)
   );

   srm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_recv_ram (
      .clock   (clock),
      .wr_en   (cmd.lookup && do_push && !is_send),
      .wr_addr (entry_addr),
      .wr_data ({handle_ff, size_ff}),
      .rd_en   (cmd.lookup && do_pop && is_send),
      .rd_addr (entry_addr),
      .rd_data (recv_rdata)
   );

   // Fetch: build the matched pair from the popped entry.
   assign opp_data   = is_send ? recv_rdata : send_rdata;
   assign pop_handle = opp_data[ENTRY_W-1 -: HANDLE_W];
   assign pop_size   = opp_data[SIZE_W-1:0];

   always_comb begin
      fetch_res            = '0;
      fetch_res.status     = ST_MATCHED;
      fetch_res.mismatch   = (pop_size != size_ff);
      fetch_res.live_count = alive_total_ff;
      if (is_send) begin
         fetch_res.send_handle = handle_ff;
         fetch_res.recv_handle = pop_handle;
         fetch_res.size        = size_ff;
      end else begin
         fetch_res.send_handle = pop_handle;
         fetch_res.recv_handle = handle_ff;
         fetch_res.size        = pop_size;
      end
   end

   assign result_now = cmd.lookup ? look_res : (cmd.fetch ? fetch_res : hold_ff);

   // Participant and pointer-valid state, committed in the lookup cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff       <= '0;
         next_rank_ff   <= '0;
         alive_total_ff <= '0;
         ptr_valid_ff   <= '0;
      end else if (cmd.lookup) begin
         alive_ff       <= alive_in;
         next_rank_ff   <= next_rank_in;
         alive_total_ff <= alive_total_in;
         if (ptr_wr) begin
            ptr_valid_ff[pair_ff] <= 1'b1;
         end
      end
   end

   // Result holding register and response register.
   always_ff @(posedge clock) begin
      if (cmd.lookup || cmd.fetch) begin
         hold_ff <= result_now;
      end
      if (cmd.load_out) begin
         out_ff <= result_now;
      end
   end

   assign rsp_status              = out_ff.status;
   assign rsp_assigned_rank       = out_ff.assigned_rank;
   assign rsp_matched_send_handle = out_ff.send_handle;
   assign rsp_matched_recv_handle = out_ff.recv_handle;
   assign rsp_matched_size        = out_ff.size;
   assign rsp_size_mismatch       = out_ff.mismatch;
   assign rsp_live_count          = out_ff.live_count;

endmodule

// ----- hdl/send_recv_request_matcher.sv -----
// A request passes the lookup state, and for a match the fetch state, before its
// result enters the response register, waiting in the emit state while it is full;
// new requests wait out the pointer read-modify-write and any entry store read.
// A waiting response does not block the next request transfer.
// Reset is synchronous: participants, rank counters and queue pointers clear at once.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send/receive request matcher
// Matches posted sends against posted receives per ordered rank pair and
// manages the table of live participants.
// ----------------------------------------------------------------------------
module send_recv_request_matcher import srm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [RANK_W-1:0]   req_source_rank,
   input  logic [RANK_W-1:0]   req_dest_rank,
   input  logic [HANDLE_W-1:0] req_request_handle,
   input  logic [SIZE_W-1:0]   req_request_size,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [RANK_W-1:0]   rsp_assigned_rank,
   output logic [HANDLE_W-1:0] rsp_matched_send_handle,
   output logic [HANDLE_W-1:0] rsp_matched_recv_handle,
   output logic [SIZE_W-1:0]   rsp_matched_size,
   output logic                rsp_size_mismatch,
   output logic [COUNT_W-1:0]  rsp_live_count
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // Controller.
   srm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   // Datapath.
   srm_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .dp_status               (dp_status),
      .req_action              (req_action),
      .req_source_rank         (req_source_rank),
      .req_dest_rank           (req_dest_rank),
      .req_request_handle      (req_request_handle),
      .req_request_size        (req_request_size),
      .rsp_status              (rsp_status),
      .rsp_assigned_rank       (rsp_assigned_rank),
      .rsp_matched_send_handle (rsp_matched_send_handle),
      .rsp_matched_recv_handle (rsp_matched_recv_handle),
      .rsp_matched_size        (rsp_matched_size),
      .rsp_size_mismatch       (rsp_size_mismatch),
      .rsp_live_count          (rsp_live_count)
   );

   // A request transfer is followed by a busy cycle.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is still in progress");

   // At most one phase command at a time.
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.lookup, cmd.fetch}))
      else $error("controller issued overlapping phase commands");

   // A result is never loaded over a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("response register overwritten before its transfer");

   // Only a match carries matched fields.
   a_match_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_MATCHED)) |->
      (!rsp_size_mismatch && (rsp_matched_size == '0) &&
       (rsp_matched_send_handle == '0) && (rsp_matched_recv_handle == '0)))
      else $error("matched fields set on a response that is not a match");

endmodule

// ----- dv/send_recv_request_matcher_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Send/receive request matcher testbench
// Drives a directed opening and then a long random stream of participant and
// post requests into the matcher. Every accepted transfer is run through a
// behavioural model of the rank table and pair queues. Each response transfer
// is checked field by field against the oldest predicted response. The sender
// works in bursts and the receiver stalls on patterns of its own, including
// one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module send_recv_request_matcher_tb;
   import srm_pkg::*;

   localparam int QDEPTH    = 4;
   localparam int SLOTS     = PAIRS * QDEPTH;
   localparam int SIDE_SEND = 0;
   localparam int SIDE_RECV = 1;
   localparam int HOLD_AT   = 800;
   localparam int HOLD_LEN  = 400;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [RANK_W-1:0]   source_rank;
      logic [RANK_W-1:0]   dest_rank;
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } matcher_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [RANK_W-1:0]   assigned_rank;
      logic [HANDLE_W-1:0] send_handle;
      logic [HANDLE_W-1:0] recv_handle;
      logic [SIZE_W-1:0]   size;
      logic                size_mismatch;
      logic [COUNT_W-1:0]  live_count;
   } matcher_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = ACT_ADD;
   logic [RANK_W-1:0]   req_source_rank = '0;
   logic [RANK_W-1:0]   req_dest_rank = '0;
   logic [HANDLE_W-1:0] req_request_handle = '0;
   logic [SIZE_W-1:0]   req_request_size = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [RANK_W-1:0]   rsp_assigned_rank;
   logic [HANDLE_W-1:0] rsp_matched_send_handle;
   logic [HANDLE_W-1:0] rsp_matched_recv_handle;
   logic [SIZE_W-1:0]   rsp_matched_size;
   logic                rsp_size_mismatch;
   logic [COUNT_W-1:0]  rsp_live_count;

   matcher_req_type pending_reqs[$];
   matcher_rsp_type expected_rsps[$];
   matcher_req_type offered_req;
   int              error_count = 0;

   // Model state: rank table and one ring per pair and side.
   bit                  rank_alive[MAX_RANKS];
   int unsigned         ranks_given;
   logic [COUNT_W-1:0]  live_total;
   logic [HANDLE_W-1:0] slot_handle[2][SLOTS];
   logic [SIZE_W-1:0]   slot_size[2][SLOTS];
   int unsigned         ring_head[2][PAIRS];
   int unsigned         ring_fill[2][PAIRS];

   // Stimulus pacing.
   int burst_left = 0;
   int gap_left = 0;

   // Receiver stall pattern.
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_mode = 0;
   int mode_left = 0;
   int pattern_phase = 0;

   send_recv_request_matcher #(
      .QUEUE_DEPTH(QDEPTH)
   ) uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_action             (req_action),
      .req_source_rank        (req_source_rank),
      .req_dest_rank          (req_dest_rank),
      .req_request_handle     (req_request_handle),
      .req_request_size       (req_request_size),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_assigned_rank      (rsp_assigned_rank),
      .rsp_matched_send_handle(rsp_matched_send_handle),
      .rsp_matched_recv_handle(rsp_matched_recv_handle),
      .rsp_matched_size       (rsp_matched_size),
      .rsp_size_mismatch      (rsp_size_mismatch),
      .rsp_live_count         (rsp_live_count)
   );

   always #5 clock = ~clock;

   // Applies one request to the model and returns the response it causes.
   function automatic matcher_rsp_type match_request(input matcher_req_type rq);
      matcher_rsp_type     r;
      int unsigned         pair;
      int unsigned         idx;
      int                  own;
      int                  opp;
      logic [HANDLE_W-1:0] popped_handle;
      logic [SIZE_W-1:0]   popped_size;
      r = '0;
      if (rq.action == ACT_ADD) begin
         if (ranks_given >= MAX_RANKS) begin
            r.status = ST_EXHAUSTED;
         end else begin
            rank_alive[ranks_given] = 1'b1;
            r.assigned_rank = ranks_given[RANK_W-1:0];
            ranks_given++;
            live_total++;
            r.status = ST_DONE;
         end
      end else if (rq.action == ACT_REMOVE) begin
         if (rank_alive[rq.source_rank]) begin
            rank_alive[rq.source_rank] = 1'b0;
            live_total--;
            r.status = ST_DONE;
         end else begin
            r.status = ST_UNKNOWN;
         end
      end else if (!rank_alive[rq.source_rank] || !rank_alive[rq.dest_rank]) begin
         r.status = ST_UNKNOWN;
      end else begin
         pair = rq.source_rank * MAX_RANKS + rq.dest_rank;
         own = (rq.action == ACT_SEND) ? SIDE_SEND : SIDE_RECV;
         opp = (rq.action == ACT_SEND) ? SIDE_RECV : SIDE_SEND;
         if (ring_fill[opp][pair] > 0) begin
            // Pop the oldest opposite request on this pair.
            idx = pair * QDEPTH + ring_head[opp][pair];
            popped_handle = slot_handle[opp][idx];
            popped_size = slot_size[opp][idx];
            ring_head[opp][pair] = (ring_head[opp][pair] + 1) % QDEPTH;
            ring_fill[opp][pair]--;
            r.status = ST_MATCHED;
            if (rq.action == ACT_SEND) begin
               r.send_handle = rq.handle;
               r.recv_handle = popped_handle;
               r.size = rq.size;
            end else begin
               r.send_handle = popped_handle;
               r.recv_handle = rq.handle;
               r.size = popped_size;
            end
            r.size_mismatch = (popped_size != rq.size);
         end else if (ring_fill[own][pair] >= QDEPTH) begin
            r.status = ST_FULL;
         end else begin
            idx = pair * QDEPTH + (ring_head[own][pair] + ring_fill[own][pair]) % QDEPTH;
            slot_handle[own][idx] = rq.handle;
            slot_size[own][idx] = rq.size;
            ring_fill[own][pair]++;
            r.status = ST_QUEUED;
         end
      end
      r.live_count = live_total;
      return r;
   endfunction

   task automatic queue_req(input logic [ACTION_W-1:0] act, input int src, input int dst,
                            input int unsigned h, input logic [SIZE_W-1:0] s);
      matcher_req_type it;
      it.action = act;
      it.source_rank = src[RANK_W-1:0];
      it.dest_rank = dst[RANK_W-1:0];
      it.handle = h[HANDLE_W-1:0];
      it.size = s;
      pending_reqs = {pending_reqs, it};
   endtask

   // Sizes from a small pool so that matched sizes agree often.
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return '0;
         2: return '1;
         default: return 32'd64;
      endcase
   endfunction

   // Mostly a few busy ranks, so that pairs see matches and full queues.
   function automatic int pick_rank();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, MAX_RANKS - 1);
      end
      return $urandom_range(0, 3);
   endfunction

   // Driver: offers pending requests in bursts and predicts each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps = {expected_rsps, match_request(offered_req)};
         end
         if (!(req_valid && req_stall)) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               offered_req = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_action <= offered_req.action;
               req_source_rank <= offered_req.source_rank;
               req_dest_rank <= offered_req.dest_rank;
               req_request_handle <= offered_req.handle;
               req_request_size <= offered_req.size;
               burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: random modes, plus one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         cycle_count = 0;
      end else begin
         cycle_count++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && cycle_count >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            pattern_phase = (pattern_phase + 1) % 5;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (pattern_phase < 3);
            endcase
         end
      end
   end

   // Monitor: checks every response transfer against the oldest prediction.
   always @(posedge clock) begin
      matcher_rsp_type got;
      matcher_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = rsp_status;
         got.assigned_rank = rsp_assigned_rank;
         got.send_handle = rsp_matched_send_handle;
         got.recv_handle = rsp_matched_recv_handle;
         got.size = rsp_matched_size;
         got.size_mismatch = rsp_size_mismatch;
         got.live_count = rsp_live_count;
         if (expected_rsps.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("%0t: response with none outstanding: status %0d", $realtime,
                        got.status);
            end
         end else begin
            want = expected_rsps.pop_front();
            if (got.status !== want.status || got.assigned_rank !== want.assigned_rank ||
                got.send_handle !== want.send_handle ||
                got.recv_handle !== want.recv_handle || got.size !== want.size ||
                got.size_mismatch !== want.size_mismatch ||
                got.live_count !== want.live_count) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: mismatch expected st=%0d rank=%0d sh=%h rh=%h sz=%h mm=%0d live=%0d",
                           $realtime, want.status, want.assigned_rank, want.send_handle,
                           want.recv_handle, want.size, want.size_mismatch, want.live_count);
                  $display("%0t:          actual   st=%0d rank=%0d sh=%h rh=%h sz=%h mm=%0d live=%0d",
                           $realtime, got.status, got.assigned_rank, got.send_handle,
                           got.recv_handle, got.size, got.size_mismatch, got.live_count);
               end
            end
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int                  roll;
      int                  src;
      int                  dst;
      int                  depth;
      int                  k;
      bit                  same;
      logic [SIZE_W-1:0]   sz;
      logic [ACTION_W-1:0] first;
      logic [ACTION_W-1:0] second;

      for (k = 0; k < MAX_RANKS; k++) begin
         rank_alive[k] = 1'b0;
      end
      for (k = 0; k < PAIRS; k++) begin
         ring_head[SIDE_SEND][k] = 0;
         ring_fill[SIDE_SEND][k] = 0;
         ring_head[SIDE_RECV][k] = 0;
         ring_fill[SIDE_RECV][k] = 0;
      end
      ranks_given = 0;
      live_total = '0;

      // Directed opening: a remove of a dead rank, every rank added, then one
      // add too many, matches at the extremes and a queue driven past full.
      queue_req(ACT_REMOVE, 3, 0, 16'h0000, 32'h0);
      for (k = 0; k < MAX_RANKS; k++) begin
         queue_req(ACT_ADD, 0, 0, 16'h0000, 32'h0);
      end
      queue_req(ACT_ADD, 15, 15, 16'hFFFF, 32'hFFFF_FFFF);
      queue_req(ACT_SEND, 15, 15, 16'hFFFF, 32'hFFFF_FFFF);
      queue_req(ACT_RECV, 15, 15, 16'h0000, 32'h0);
      queue_req(ACT_RECV, 0, 15, 16'h1234, 32'd5);
      queue_req(ACT_SEND, 0, 15, 16'hABCD, 32'd5);
      for (k = 0; k <= QDEPTH; k++) begin
         queue_req(ACT_SEND, 1, 2, 16'h0100 + k, 32'd100 + k);
      end
      queue_req(ACT_REMOVE, 14, 0, 16'h0000, 32'h0);
      queue_req(ACT_RECV, 14, 1, 16'h5555, 32'hAAAA_AAAA);

      // Random part: mostly posts on busy pairs, with noise and late removes.
      while (pending_reqs.size() < 530) begin
         roll = $urandom_range(0, 99);
         if (roll < 62) begin
            queue_req($urandom_range(0, 1) ? ACT_SEND : ACT_RECV, pick_rank(), pick_rank(),
                      $urandom_range(0, 65535), pick_size());
         end else if (roll < 80) begin
            // A run of posts on one pair followed by the opposite side.
            src = pick_rank();
            dst = pick_rank();
            depth = $urandom_range(1, QDEPTH + 1);
            sz = pick_size();
            same = 1'($urandom_range(0, 1));
            first = $urandom_range(0, 1) ? ACT_SEND : ACT_RECV;
            second = (first == ACT_SEND) ? ACT_RECV : ACT_SEND;
            for (k = 0; k < depth; k++) begin
               queue_req(first, src, dst, $urandom_range(0, 65535), same ? sz : pick_size());
            end
            for (k = 0; k < depth; k++) begin
               queue_req(second, src, dst, $urandom_range(0, 65535), same ? sz : pick_size());
            end
         end else if (roll < 90) begin
            queue_req($urandom_range(0, 1) ? ACT_SEND : ACT_RECV,
                      $urandom_range(0, MAX_RANKS - 1), $urandom_range(0, MAX_RANKS - 1),
                      $urandom_range(0, 65535), $urandom);
         end else if (roll < 95) begin
            queue_req(ACT_ADD, $urandom_range(0, MAX_RANKS - 1),
                      $urandom_range(0, MAX_RANKS - 1), $urandom_range(0, 65535), $urandom);
         end else if (pending_reqs.size() > 380) begin
            queue_req(ACT_REMOVE, $urandom_range(0, MAX_RANKS - 1),
                      $urandom_range(0, MAX_RANKS - 1), $urandom_range(0, 65535), $urandom);
         end else begin
            // Rank 14 is already gone, so this remove is refused.
            queue_req(ACT_REMOVE, 14, $urandom_range(0, MAX_RANKS - 1),
                      $urandom_range(0, 65535), $urandom);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for the stream to drain, then give stray responses time to show.
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/srm_pkg.sv
hdl/srm_ram.sv
hdl/srm_ctrl.sv
hdl/srm_datapath.sv
hdl/send_recv_request_matcher.sv
dv/send_recv_request_matcher_tb.sv
